// File: hw/rtl/account_hash_table_assert.svh
// Assertion macros used by the hash table RTL.
`ifndef ACCOUNT_HASH_TABLE_ASSERT_SVH
`define ACCOUNT_HASH_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// Clocked property check, disabled while reset is asserted.
`define AHT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked property check that also holds during reset.
`define AHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define AHT_ASSERT(lbl, clk, rstn, prop, msg)
`define AHT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hw/rtl/aht_pkg.sv
// Package for the account hash table: sizes, codes and record types.
package aht_pkg;

    // Table geometry
    localparam int BUCKET_COUNT = 753;
    localparam int WAYS         = 4;
    localparam int KEY_BASE     = 100000;

    // Field widths
    localparam int KEY_W    = 20;
    localparam int DATA_W   = 64;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    // Derived widths
    localparam int BKT_W  = $clog2(BUCKET_COUNT);
    localparam int FILL_W = $clog2(WAYS + 1);

    // Reciprocal for the bucket modulo: q = (off * RECIP) >> DIV_SHIFT is q or q-1
    localparam int DIV_SHIFT = 30;
    localparam int RECIP     = (2 ** DIV_SHIFT) / BUCKET_COUNT;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = KEY_W + RECIP_W;
    localparam int QUO_W     = PROD_W - DIV_SHIFT;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] name;
        logic [DATA_W-1:0] balance;
    } t_slot;

    // One memory row holds a whole bucket: fill count and all ways
    typedef struct packed {
        logic [FILL_W-1:0]     fill;
        t_slot [WAYS-1:0]      slots;
    } t_row;

endpackage

// File: hw/rtl/aht_channels.sv
// Request and response channel interfaces of the account hash table.
interface aht_req_if;
    logic                           valid;
    logic                           ready;
    logic [aht_pkg::OP_W-1:0]       op;
    logic [aht_pkg::KEY_W-1:0]      account_number;
    logic [aht_pkg::DATA_W-1:0]     owner_name;
    logic [aht_pkg::DATA_W-1:0]     balance_bits;

    modport source (output valid, op, account_number, owner_name, balance_bits,
                    input ready);
    modport sink   (input valid, op, account_number, owner_name, balance_bits,
                    output ready);
endinterface

interface aht_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [aht_pkg::STATUS_W-1:0]   status;
    logic [aht_pkg::KEY_W-1:0]      found_account;
    logic [aht_pkg::DATA_W-1:0]     found_name;
    logic [aht_pkg::DATA_W-1:0]     found_balance;

    modport source (output valid, status, found_account, found_name, found_balance,
                    input ready);
    modport sink   (input valid, status, found_account, found_name, found_balance,
                    output ready);
endinterface

// File: hw/rtl/account_hash_table.sv
// Account hash table: bounded separate chaining over one row-per-bucket memory.
//
// Each request beat (insert, delete or search) gives one response beat. After
// reset the block sweeps the bucket memory to empty, one row per cycle; no
// request is taken until it finishes. An item then passes through its steps
// in order: accept in S_IDLE, the reciprocal multiply in S_DIV1 and the
// remainder in S_DIV2 that form the bucket index, the synchronous memory read
// of the bucket row in S_READ (where the correction picks the index), and
// S_MODIFY, which compares all ways, updates the row, writes it back and loads
// the response register. A new request is not accepted until the last one has
// left S_MODIFY, as the single memory port and this read-modify-write pass
// allow one item in flight; a request is accepted again as soon as the block
// is back to idle, even while the last response still waits to be taken, and
// the update stage holds only if the response register is still occupied.
`include "account_hash_table_assert.svh"

module account_hash_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aht_req_if.sink   i_req,
    aht_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_READ,
        S_MODIFY
    } t_state;

    localparam logic [aht_pkg::KEY_W-1:0]     KEY_BASE_K = aht_pkg::KEY_W'(aht_pkg::KEY_BASE);
    localparam logic [aht_pkg::RECIP_W-1:0]   RECIP_K    = aht_pkg::RECIP_W'(aht_pkg::RECIP);
    localparam logic [aht_pkg::KEY_W:0]       BKT_CNT_K  =
        (aht_pkg::KEY_W + 1)'(aht_pkg::BUCKET_COUNT);
    localparam logic [aht_pkg::BKT_W:0]       BKT_CNT_R  =
        (aht_pkg::BKT_W + 1)'(aht_pkg::BUCKET_COUNT);
    localparam logic [aht_pkg::BKT_W-1:0]     BKT_LAST   =
        aht_pkg::BKT_W'(aht_pkg::BUCKET_COUNT - 1);
    localparam logic [aht_pkg::FILL_W-1:0]    WAYS_K     = aht_pkg::FILL_W'(aht_pkg::WAYS);

    // Control state
    t_state                        r_state;
    logic [aht_pkg::BKT_W-1:0]     r_clr_idx;
    logic                          r_out_valid;

    // Request payload held for the duration of the item
    aht_pkg::t_op                  r_op;
    logic [aht_pkg::KEY_W-1:0]     r_key;
    logic [aht_pkg::DATA_W-1:0]    r_name;
    logic [aht_pkg::DATA_W-1:0]    r_bal;
    logic [aht_pkg::KEY_W-1:0]     r_off;
    logic [aht_pkg::PROD_W-1:0]    r_prod;
    logic [aht_pkg::BKT_W:0]       r_rem;
    logic [aht_pkg::BKT_W-1:0]     r_bucket;

    // Response register
    aht_pkg::t_status              r_status;
    logic [aht_pkg::KEY_W-1:0]     r_found_acc;
    logic [aht_pkg::DATA_W-1:0]    r_found_name;
    logic [aht_pkg::DATA_W-1:0]    r_found_bal;

    // Bucket memory
    aht_pkg::t_row                 r_mem [aht_pkg::BUCKET_COUNT];
    aht_pkg::t_row                 r_rd_row;
    logic                          mem_we;
    logic [aht_pkg::BKT_W-1:0]     mem_waddr;
    aht_pkg::t_row                 mem_wdata;
    logic                          mem_re;

    // Datapath signals
    logic [aht_pkg::QUO_W-1:0]     quo;
    logic [aht_pkg::KEY_W:0]       rem_full;
    logic [aht_pkg::BKT_W-1:0]     bucket;
    logic                          out_free;
    logic [aht_pkg::FILL_W-1:0]    fill;
    logic                          hit;
    logic [aht_pkg::FILL_W-1:0]    hit_way;
    aht_pkg::t_row                 mod_row;
    logic                          mod_wr;
    aht_pkg::t_status              mod_status;
    aht_pkg::t_slot                mod_found;

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.found_account = r_found_acc;
    assign o_rsp.found_name    = r_found_name;
    assign o_rsp.found_balance = r_found_bal;

    // Response register can take a new beat this cycle
    assign out_free = !r_out_valid || o_rsp.ready;

    // Bucket modulo: remainder estimate below twice the bucket count, then one correction
    assign quo      = r_prod[aht_pkg::PROD_W-1:aht_pkg::DIV_SHIFT];
    assign rem_full = {1'b0, r_off} - ((aht_pkg::KEY_W + 1)'(quo) * BKT_CNT_K);
    assign bucket   = (r_rem >= BKT_CNT_R) ? aht_pkg::BKT_W'(r_rem - BKT_CNT_R)
                                           : aht_pkg::BKT_W'(r_rem);

    // Way compare and row update
    always_comb begin
        fill       = r_rd_row.fill;
        hit        = 1'b0;
        hit_way    = '0;
        mod_row    = r_rd_row;
        mod_wr     = 1'b0;
        mod_status = aht_pkg::ST_NOT_FOUND;
        mod_found  = '0;

        // first valid way whose key matches
        for (int w = 0; w < aht_pkg::WAYS; w++) begin
            if (!hit && (aht_pkg::FILL_W'(w) < fill) && (r_rd_row.slots[w].key == r_key)) begin
                hit     = 1'b1;
                hit_way = aht_pkg::FILL_W'(w);
            end
        end

        unique case (r_op)
            aht_pkg::OP_INSERT: begin
                if (fill >= WAYS_K) begin
                    mod_status = aht_pkg::ST_FULL;
                end else begin
                    for (int w = 0; w < aht_pkg::WAYS; w++) begin
                        if (aht_pkg::FILL_W'(w) == fill) begin
                            mod_row.slots[w].key     = r_key;
                            mod_row.slots[w].name    = r_name;
                            mod_row.slots[w].balance = r_bal;
                        end
                    end
                    mod_row.fill = fill + 1'b1;
                    mod_wr       = 1'b1;
                    mod_status   = aht_pkg::ST_OK;
                end
            end
            aht_pkg::OP_DELETE: begin
                if (hit) begin
                    // later ways move up one place to close the gap
                    for (int w = 0; w < aht_pkg::WAYS - 1; w++) begin
                        if (aht_pkg::FILL_W'(w) >= hit_way) begin
                            mod_row.slots[w] = r_rd_row.slots[w + 1];
                        end
                    end
                    mod_row.fill = fill - 1'b1;
                    mod_wr       = 1'b1;
                    mod_status   = aht_pkg::ST_OK;
                end
            end
            aht_pkg::OP_SEARCH: begin
                if (hit) begin
                    for (int w = 0; w < aht_pkg::WAYS; w++) begin
                        if (aht_pkg::FILL_W'(w) == hit_way) begin
                            mod_found = r_rd_row.slots[w];
                        end
                    end
                    mod_status = aht_pkg::ST_OK;
                end
            end
            default: begin
                mod_status = aht_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // Memory port control: clearing sweep or write-back of the updated row
    always_comb begin
        mem_re    = (r_state == S_READ);
        mem_we    = 1'b0;
        mem_waddr = r_bucket;
        mem_wdata = mod_row;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = '0;
        end else if (r_state == S_MODIFY) begin
            mem_we = mod_wr && out_free;
        end
    end

    // Bucket memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_row <= r_mem[bucket];
        end
    end

    // Sequencer, datapath registers and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a taken beat empties the register unless the update stage refills it
            if (o_rsp.valid && o_rsp.ready && (r_state != S_MODIFY)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == BKT_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op    <= aht_pkg::t_op'(i_req.op);
                        r_key   <= i_req.account_number;
                        r_name  <= i_req.owner_name;
                        r_bal   <= i_req.balance_bits;
                        r_off   <= i_req.account_number - KEY_BASE_K;
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    r_prod  <= aht_pkg::PROD_W'(r_off) * aht_pkg::PROD_W'(RECIP_K);
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    r_rem   <= rem_full[aht_pkg::BKT_W:0];
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_bucket <= bucket;
                    r_state  <= S_MODIFY;
                end
                S_MODIFY: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_status     <= mod_status;
                        r_found_acc  <= mod_found.key;
                        r_found_name <= mod_found.name;
                        r_found_bal  <= mod_found.balance;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // No request is taken while the memory is being cleared
    `AHT_ASSERT(a_no_req_in_clear, i_clk, i_rst_n, (r_state == S_CLEAR) |-> !i_req.ready, "request taken during clear")
    // Memory is written only by the clearing sweep or the update stage
    `AHT_ASSERT(a_write_phase, i_clk, i_rst_n, mem_we |-> ((r_state == S_CLEAR) || (r_state == S_MODIFY)), "memory write outside clear or update")
    // The remainder is below twice the bucket count when the row is read, so the index is in range
    `AHT_ASSERT(a_bucket_range, i_clk, i_rst_n, (r_state == S_READ) |-> (r_rem < (2 * BKT_CNT_R)), "bucket remainder out of range")
    // A written-back row never holds more records than there are ways
    `AHT_ASSERT(a_fill_bound, i_clk, i_rst_n, (mem_we && (r_state == S_MODIFY)) |-> (mem_wdata.fill <= WAYS_K), "bucket fill above way count")
    // A new response appears only right after the update stage
    `AHT_ASSERT(a_rsp_origin, i_clk, i_rst_n, (o_rsp.valid && !$past(o_rsp.valid)) |-> ($past(r_state) == S_MODIFY), "response without update stage")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the account hash table: random and directed requests.
`timescale 1ns / 1ps

module testbench;

    // Op code left unused by the block; it must answer not found
    localparam logic [aht_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Hot buckets that the random part crowds so chains fill, overflow and shift
    localparam int HOT_BUCKET [4] = '{0, 5, 376, 752};
    localparam int HOT_KEYS       = 6;
    localparam int RANDOM_ITEMS   = 1026;
    localparam int DRAIN_AT       = 500;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic [aht_pkg::OP_W-1:0]   op;
        logic [aht_pkg::KEY_W-1:0]  acct;
        logic [aht_pkg::DATA_W-1:0] name;
        logic [aht_pkg::DATA_W-1:0] bal;
        bit                         drain;   // hold this beat until every response is back
    } req_t;

    typedef struct {
        aht_pkg::t_status           status;
        logic [aht_pkg::KEY_W-1:0]  acct;
        logic [aht_pkg::DATA_W-1:0] name;
        logic [aht_pkg::DATA_W-1:0] bal;
    } rsp_t;

    logic i_clk;
    logic i_rst_n = 1'b0;

    // Bus-side copies of the request and response controls, known from time 0
    logic                       req_valid = 1'b0;
    logic [aht_pkg::OP_W-1:0]   req_op    = '0;
    logic [aht_pkg::KEY_W-1:0]  req_acct  = '0;
    logic [aht_pkg::DATA_W-1:0] req_name  = '0;
    logic [aht_pkg::DATA_W-1:0] req_bal   = '0;
    logic                       rsp_ready = 1'b0;

    aht_req_if req_ch ();
    aht_rsp_if rsp_ch ();

    assign req_ch.valid          = req_valid;
    assign req_ch.op             = req_op;
    assign req_ch.account_number = req_acct;
    assign req_ch.owner_name     = req_name;
    assign req_ch.balance_bits   = req_bal;
    assign rsp_ch.ready          = rsp_ready;

    account_hash_table u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Predicted table contents
    logic [aht_pkg::FILL_W-1:0] tbl_fill [aht_pkg::BUCKET_COUNT];
    logic [aht_pkg::KEY_W-1:0]  tbl_key  [aht_pkg::BUCKET_COUNT][aht_pkg::WAYS];
    logic [aht_pkg::DATA_W-1:0] tbl_name [aht_pkg::BUCKET_COUNT][aht_pkg::WAYS];
    logic [aht_pkg::DATA_W-1:0] tbl_bal  [aht_pkg::BUCKET_COUNT][aht_pkg::WAYS];

    req_t pending_req [$];
    rsp_t expected_rsp [$];

    int sent_cnt  = 0;
    int err_cnt   = 0;
    int ok_cnt    = 0;
    int miss_cnt  = 0;
    int full_cnt  = 0;
    int gap_left  = 0;
    int stall_left = 0;
    req_t on_bus;

    // Quiet stretches: no gaps and no stalls on either side
    logic calm;
    assign calm = ((sent_cnt / 128) % 4) == 1;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Bucket index: the 20-bit offset wraps below the key base
    function automatic int bucket_index(logic [aht_pkg::KEY_W-1:0] key);
        logic [aht_pkg::KEY_W-1:0] off;
        off = key - aht_pkg::KEY_W'(aht_pkg::KEY_BASE);
        return int'(off) % aht_pkg::BUCKET_COUNT;
    endfunction

    // Apply one request to the predicted table and return its response
    function automatic rsp_t table_apply(req_t r);
        int   b;
        int   w;
        int   hit;
        int   fill;
        rsp_t e;
        b        = bucket_index(r.acct);
        fill     = int'(tbl_fill[b]);
        e.status = aht_pkg::ST_NOT_FOUND;
        e.acct   = '0;
        e.name   = '0;
        e.bal    = '0;
        hit      = -1;
        for (w = 0; w < fill; w++) begin
            if (hit < 0 && tbl_key[b][w] == r.acct) hit = w;
        end
        case (r.op)
            aht_pkg::OP_INSERT: begin
                if (fill >= aht_pkg::WAYS) begin
                    e.status = aht_pkg::ST_FULL;
                end else begin
                    tbl_key[b][fill]  = r.acct;
                    tbl_name[b][fill] = r.name;
                    tbl_bal[b][fill]  = r.bal;
                    tbl_fill[b]       = aht_pkg::FILL_W'(fill + 1);
                    e.status          = aht_pkg::ST_OK;
                end
            end
            aht_pkg::OP_DELETE: begin
                if (hit >= 0) begin
                    // close the gap behind the removed record
                    for (w = hit; w + 1 < fill; w++) begin
                        tbl_key[b][w]  = tbl_key[b][w+1];
                        tbl_name[b][w] = tbl_name[b][w+1];
                        tbl_bal[b][w]  = tbl_bal[b][w+1];
                    end
                    tbl_fill[b] = aht_pkg::FILL_W'(fill - 1);
                    e.status    = aht_pkg::ST_OK;
                end
            end
            aht_pkg::OP_SEARCH: begin
                if (hit >= 0) begin
                    e.status = aht_pkg::ST_OK;
                    e.acct   = tbl_key[b][hit];
                    e.name   = tbl_name[b][hit];
                    e.bal    = tbl_bal[b][hit];
                end
            end
            default: ;
        endcase
        return e;
    endfunction

    function automatic logic [aht_pkg::KEY_W-1:0] hot_key(int slot, int k);
        return aht_pkg::KEY_W'(aht_pkg::KEY_BASE + HOT_BUCKET[slot] +
                               k * aht_pkg::BUCKET_COUNT);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(99) < 80) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    function automatic req_t random_req(bit drain);
        req_t r;
        int   sel;
        sel = $urandom_range(99);
        if (sel < 35)      r.op = aht_pkg::OP_INSERT;
        else if (sel < 65) r.op = aht_pkg::OP_DELETE;
        else if (sel < 95) r.op = aht_pkg::OP_SEARCH;
        else               r.op = OP_UNUSED;
        if ($urandom_range(99) < 85)
            r.acct = hot_key($urandom_range(3), $urandom_range(HOT_KEYS - 1));
        else
            r.acct = aht_pkg::KEY_W'($urandom);
        r.name  = {$urandom, $urandom};
        r.bal   = {$urandom, $urandom};
        r.drain = drain;
        return r;
    endfunction

    task automatic add_req(logic [aht_pkg::OP_W-1:0] op, logic [aht_pkg::KEY_W-1:0] acct,
                           logic [aht_pkg::DATA_W-1:0] name, logic [aht_pkg::DATA_W-1:0] bal,
                           bit drain);
        req_t r;
        r.op    = op;
        r.acct  = acct;
        r.name  = name;
        r.bal   = bal;
        r.drain = drain;
        pending_req = {pending_req, r};
    endtask

    task automatic note_error(string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("ERR @%0t: %s", $realtime, msg);
    endtask

    // Driver: present the next pending beat, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_valid <= 1'b0;
            gap_left  = 0;
        end else begin
            if (req_valid && req_ch.ready) begin
                expected_rsp = {expected_rsp, table_apply(on_bus)};
                sent_cnt++;
            end
            if (!req_valid || req_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_valid <= 1'b0;
                end else if (pending_req.size() == 0 ||
                             (pending_req[0].drain && expected_rsp.size() != 0)) begin
                    req_valid <= 1'b0;
                end else begin
                    on_bus    = pending_req.pop_front();
                    req_valid <= 1'b1;
                    req_op    <= on_bus.op;
                    req_acct  <= on_bus.acct;
                    req_name  <= on_bus.name;
                    req_bal   <= on_bus.bal;
                    if (!calm && $urandom_range(99) < 20) gap_left = pick_gap();
                end
            end
        end
    end

    // Monitor: take response beats under random back-pressure and check them
    always @(posedge i_clk) begin
        rsp_t e;
        if (!i_rst_n) begin
            rsp_ready  <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ready) begin
                if (expected_rsp.size() == 0) begin
                    note_error($sformatf("response beat with none pending: status %0d",
                                         rsp_ch.status));
                end else begin
                    e = expected_rsp.pop_front();
                    case (e.status)
                        aht_pkg::ST_OK:        ok_cnt++;
                        aht_pkg::ST_NOT_FOUND: miss_cnt++;
                        default:               full_cnt++;
                    endcase
                    if (rsp_ch.status !== e.status || rsp_ch.found_account !== e.acct ||
                        rsp_ch.found_name !== e.name || rsp_ch.found_balance !== e.bal)
                        note_error($sformatf(
                            "exp st %0d acct %0d name %h bal %h / got st %0d acct %0d name %h bal %h",
                            e.status, e.acct, e.name, e.bal, rsp_ch.status,
                            rsp_ch.found_account, rsp_ch.found_name, rsp_ch.found_balance));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
                if (!calm && $urandom_range(99) < 15) stall_left = pick_gap();
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int i;
        for (i = 0; i < aht_pkg::BUCKET_COUNT; i++) tbl_fill[i] = '0;

        // Extremes of key and payload
        add_req(aht_pkg::OP_INSERT, 20'd100000, '1, '1, 1'b0);
        add_req(aht_pkg::OP_SEARCH, 20'd100000, '0, '0, 1'b0);
        add_req(aht_pkg::OP_INSERT, 20'd999999, '0, '0, 1'b0);
        add_req(aht_pkg::OP_SEARCH, 20'd999999, '1, '1, 1'b0);
        // Fill one bucket with a duplicate key, then overflow it
        add_req(aht_pkg::OP_INSERT, hot_key(1, 0), 64'hAAAA_AAAA_AAAA_AAAA,
                64'h5555_5555_5555_5555, 1'b0);
        add_req(aht_pkg::OP_INSERT, hot_key(1, 1), 64'h0123_4567_89AB_CDEF,
                64'hFEDC_BA98_7654_3210, 1'b0);
        add_req(aht_pkg::OP_INSERT, hot_key(1, 2), 64'h5555_5555_5555_5555,
                64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        add_req(aht_pkg::OP_INSERT, hot_key(1, 1), 64'h8000_0000_0000_0001,
                64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
        add_req(aht_pkg::OP_INSERT, hot_key(1, 3), 64'h1111_2222_3333_4444,
                64'h4444_3333_2222_1111, 1'b0);
        add_req(aht_pkg::OP_SEARCH, hot_key(1, 1), '0, '0, 1'b0);
        // Delete the first copy; the later one moves up
        add_req(aht_pkg::OP_DELETE, hot_key(1, 1), '0, '0, 1'b0);
        add_req(aht_pkg::OP_SEARCH, hot_key(1, 1), '0, '0, 1'b0);
        add_req(aht_pkg::OP_DELETE, hot_key(1, 4), '0, '0, 1'b0);
        add_req(aht_pkg::OP_SEARCH, hot_key(1, 4), '0, '0, 1'b0);
        add_req(OP_UNUSED, hot_key(1, 0), '1, '1, 1'b0);
        // Keys outside the six-digit range
        add_req(aht_pkg::OP_INSERT, 20'd0, 64'hDEAD_BEEF_0000_0001,
                64'h0000_0001_DEAD_BEEF, 1'b0);
        add_req(aht_pkg::OP_SEARCH, 20'd0, '0, '0, 1'b0);
        add_req(aht_pkg::OP_INSERT, '1, 64'hFFFF_0000_FFFF_0000,
                64'h0000_FFFF_0000_FFFF, 1'b0);
        add_req(aht_pkg::OP_SEARCH, '1, '0, '0, 1'b0);
        add_req(aht_pkg::OP_DELETE, 20'd100000, '0, '0, 1'b0);
        add_req(aht_pkg::OP_SEARCH, 20'd100000, '0, '0, 1'b0);
        add_req(aht_pkg::OP_DELETE, hot_key(1, 0), '0, '0, 1'b0);
        add_req(aht_pkg::OP_SEARCH, hot_key(1, 2), '0, '0, 1'b1);
        add_req(aht_pkg::OP_DELETE, '1, '0, '0, 1'b0);

        for (i = 0; i < RANDOM_ITEMS; i++) pending_req = {pending_req, random_req(i == DRAIN_AT)};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_req.size() != 0 || req_valid) @(posedge i_clk);
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("Ran %0d requests over hot and random buckets, with gaps and back-pressure.",
                 sent_cnt);
        $display("Responses: %0d ok, %0d not found, %0d bucket full; %0d mismatches.",
                 ok_cnt, miss_cnt, full_cnt, err_cnt);
        if (err_cnt == 0 && expected_rsp.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d requests sent and %0d responses pending.",
                 sent_cnt, expected_rsp.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
